FILE: sv/alb_smth_pkg.sv
// constants and register codes for the ambient light brightness smoother
package alb_smth_pkg;

   localparam int LUX_W   = 21;
   localparam int LEVEL_W = 8;
   localparam int SHIFT_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam int AVG_WINDOW = 1000;
   localparam int START_LUX  = 25000;
   localparam int LUX_MAX    = 1573000;

   localparam int RESET_SHIFT = 7;
   localparam int RESET_MIN   = 10;
   localparam int RESET_MAX   = 80;

   // start level: start average shifted and clamped like any target
   localparam int START_SHIFTED = START_LUX >> RESET_SHIFT;
   localparam int START_RAISED  = (START_SHIFTED < RESET_MIN) ? RESET_MIN : START_SHIFTED;
   localparam int START_LEVEL   = (START_RAISED > RESET_MAX) ? RESET_MAX : START_RAISED;

   // remainder and offset so the signed step stays non-negative
   localparam int REM_W   = $clog2(AVG_WINDOW);
   localparam int OFF_Q   = (LUX_MAX + AVG_WINDOW - 1) / AVG_WINDOW;
   localparam int OFF_LUX = OFF_Q * AVG_WINDOW;
   localparam int E_MAX   = LUX_MAX + AVG_WINDOW - 1 + OFF_LUX;
   localparam int E_W     = $clog2(E_MAX + 1);
   localparam int Q_W     = $clog2(E_MAX / AVG_WINDOW + 1);

   // reciprocal of the window, exact for every value up to E_MAX
   localparam int WIN_W   = $clog2(AVG_WINDOW + 1);
   localparam int RECIP_K = E_W + WIN_W;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_K) + AVG_WINDOW - 1) / AVG_WINDOW;
   localparam int M_W    = RECIP_K - WIN_W + 2;
   localparam int PROD_W = E_W + M_W;
   localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP);

   localparam logic [CSR_IDX_W-1:0] CSR_LUX_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL = 2'd2;

endpackage

FILE: sv/ambient_light_brightness_smoother_unit.sv
// ambient light brightness smoother: moving average, level mapping and one-step slew
//
// Every accepted item (one light sample in millilux) gives exactly one result item,
// the display brightness level after one step of slew toward the target. An item is
// registered on entry and its result is registered on exit; a new item can be taken
// every cycle while rsp_stall does not hold the result, so the sustained rate is one
// item per cycle. The per-item loop through the average is one multiply by the
// reciprocal of the 1000-sample window plus an add and compare, all combinational.
// Configuration writes are taken at any time (csr_ready stays high) and should only
// be made while no item is in flight; unknown register indexes are ignored.
module ambient_light_brightness_smoother_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [alb_smth_pkg::LUX_W-1:0]         req_ambient_lux,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [alb_smth_pkg::LEVEL_W-1:0]       rsp_brightness,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [alb_smth_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [alb_smth_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                               in_valid_ff;
   logic [alb_smth_pkg::LUX_W-1:0]     sample_ff;
   logic                               out_valid_ff;
   logic [alb_smth_pkg::LEVEL_W-1:0]   bright_ff;

   logic [alb_smth_pkg::SHIFT_W-1:0]   shift_ff;
   logic [alb_smth_pkg::LEVEL_W-1:0]   min_ff;
   logic [alb_smth_pkg::LEVEL_W-1:0]   max_ff;

   logic [alb_smth_pkg::LUX_W-1:0]     avg_ff, avg_in;
   logic [alb_smth_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [alb_smth_pkg::LEVEL_W-1:0]   level_ff, level_in;

   logic                               advance;
   logic [alb_smth_pkg::LUX_W-1:0]     sample_clamped;
   logic [alb_smth_pkg::E_W-1:0]       step_e;
   logic [alb_smth_pkg::PROD_W-1:0]    prod;
   logic [alb_smth_pkg::Q_W-1:0]       quot;
   logic [alb_smth_pkg::E_W-1:0]       quot_w;
   logic [alb_smth_pkg::E_W-1:0]       avg_sum;
   logic [alb_smth_pkg::LUX_W-1:0]     shifted;
   logic [alb_smth_pkg::LEVEL_W-1:0]   target;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid      = out_valid_ff;
   assign rsp_brightness = bright_ff;

   always_comb begin
      sample_clamped = (sample_ff > alb_smth_pkg::LUX_W'(alb_smth_pkg::LUX_MAX))
                     ? alb_smth_pkg::LUX_W'(alb_smth_pkg::LUX_MAX) : sample_ff;
      // offset step: sample + remainder - average, biased by a multiple of the window
      step_e = alb_smth_pkg::E_W'(sample_clamped) + alb_smth_pkg::E_W'(rem_ff)
             + alb_smth_pkg::E_W'(alb_smth_pkg::OFF_LUX) - alb_smth_pkg::E_W'(avg_ff);
      prod   = alb_smth_pkg::PROD_W'(step_e) * alb_smth_pkg::PROD_W'(alb_smth_pkg::RECIP_M);
      quot   = prod[alb_smth_pkg::RECIP_K +: alb_smth_pkg::Q_W];
      quot_w = alb_smth_pkg::E_W'(quot) * alb_smth_pkg::E_W'(alb_smth_pkg::AVG_WINDOW);
      rem_in = alb_smth_pkg::REM_W'(step_e - quot_w);
      avg_sum = alb_smth_pkg::E_W'(avg_ff) + alb_smth_pkg::E_W'(quot)
              - alb_smth_pkg::E_W'(alb_smth_pkg::OFF_Q);
      avg_in = avg_sum[alb_smth_pkg::LUX_W-1:0];

      shifted = avg_in >> shift_ff;
      if (shifted < alb_smth_pkg::LUX_W'(min_ff)) begin
         target = min_ff;
      end else begin
         target = shifted[alb_smth_pkg::LEVEL_W-1:0];
      end
      if (shifted < alb_smth_pkg::LUX_W'(min_ff)) begin
         if (min_ff > max_ff) begin
            target = max_ff;
         end
      end else if (shifted > alb_smth_pkg::LUX_W'(max_ff)) begin
         target = max_ff;
      end

      if (target > level_ff) begin
         level_in = level_ff + alb_smth_pkg::LEVEL_W'(1);
      end else if (target < level_ff) begin
         level_in = level_ff - alb_smth_pkg::LEVEL_W'(1);
      end else begin
         level_in = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shift_ff <= alb_smth_pkg::SHIFT_W'(alb_smth_pkg::RESET_SHIFT);
         min_ff   <= alb_smth_pkg::LEVEL_W'(alb_smth_pkg::RESET_MIN);
         max_ff   <= alb_smth_pkg::LEVEL_W'(alb_smth_pkg::RESET_MAX);
         avg_ff   <= alb_smth_pkg::LUX_W'(alb_smth_pkg::START_LUX);
         rem_ff   <= '0;
         level_ff <= alb_smth_pkg::LEVEL_W'(alb_smth_pkg::START_LEVEL);
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            avg_ff   <= avg_in;
            rem_ff   <= rem_in;
            level_ff <= level_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               alb_smth_pkg::CSR_LUX_SHIFT: shift_ff <= csr_wdata[alb_smth_pkg::SHIFT_W-1:0];
               alb_smth_pkg::CSR_MIN_LEVEL: min_ff   <= csr_wdata[alb_smth_pkg::LEVEL_W-1:0];
               alb_smth_pkg::CSR_MAX_LEVEL: max_ff   <= csr_wdata[alb_smth_pkg::LEVEL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         sample_ff <= req_ambient_lux;
      end
      if (advance) begin
         bright_ff <= level_in;
      end
   end

   a_rem_below_window: assert property (@(posedge clock) disable iff (reset)
      rem_ff < alb_smth_pkg::REM_W'(alb_smth_pkg::AVG_WINDOW))
      else $error("average remainder reached the window");

   a_avg_in_range: assert property (@(posedge clock) disable iff (reset)
      avg_ff <= alb_smth_pkg::LUX_W'(alb_smth_pkg::LUX_MAX))
      else $error("average above the clamp level");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (level_ff == $past(level_ff)
                || level_ff == $past(level_ff) + alb_smth_pkg::LEVEL_W'(1)
                || level_ff == $past(level_ff) - alb_smth_pkg::LEVEL_W'(1)))
      else $error("level moved by more than one step");

   a_result_matches_level: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_valid_ff && bright_ff == level_ff))
      else $error("result differs from the current level");

endmodule

FILE: test/tb_top.sv
// testbench for the ambient light brightness smoother: random and directed light samples
`timescale 1ns / 100ps

module tb_top;

   localparam int CLK_PERIOD = 20;
   localparam int LUX_TOP = (1 << alb_smth_pkg::LUX_W) - 1;
   localparam logic [alb_smth_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [alb_smth_pkg::LUX_W-1:0] req_ambient_lux = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [alb_smth_pkg::LEVEL_W-1:0] rsp_brightness;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [alb_smth_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [alb_smth_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and the smoothing state
   logic [alb_smth_pkg::SHIFT_W-1:0] cfg_shift;
   logic [alb_smth_pkg::LEVEL_W-1:0] cfg_min_level;
   logic [alb_smth_pkg::LEVEL_W-1:0] cfg_max_level;
   logic [alb_smth_pkg::LUX_W-1:0] lux_avg;
   logic [9:0] lux_carry;
   logic [alb_smth_pkg::LEVEL_W-1:0] level_held;

   logic [alb_smth_pkg::LUX_W-1:0] lux_backlog[$];
   logic [alb_smth_pkg::LEVEL_W-1:0] brightness_due[$];
   logic [alb_smth_pkg::LEVEL_W-1:0] want_level;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int samples_taken = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int settings_used = 1;
   int error_count = 0;

   ambient_light_brightness_smoother_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_ambient_lux(req_ambient_lux),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_brightness(rsp_brightness),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [alb_smth_pkg::LEVEL_W-1:0] level_for_lux(
      input logic [alb_smth_pkg::LUX_W-1:0] avg);
      logic [alb_smth_pkg::LUX_W-1:0] t;
      t = avg >> cfg_shift;
      if (t < cfg_min_level) t = cfg_min_level;
      if (t > cfg_max_level) t = cfg_max_level;
      return t[alb_smth_pkg::LEVEL_W-1:0];
   endfunction

   function automatic logic [alb_smth_pkg::LEVEL_W-1:0] advance_brightness(
      input logic [alb_smth_pkg::LUX_W-1:0] lux);
      logic [alb_smth_pkg::LUX_W-1:0] clipped;
      logic [41:0] total;
      logic [alb_smth_pkg::LEVEL_W-1:0] target;
      clipped = (lux > alb_smth_pkg::LUX_MAX)
              ? alb_smth_pkg::LUX_W'(alb_smth_pkg::LUX_MAX) : lux;
      total = 42'(lux_avg) * 42'(alb_smth_pkg::AVG_WINDOW - 1) + 42'(clipped)
            + 42'(lux_carry);
      lux_avg = alb_smth_pkg::LUX_W'(total / alb_smth_pkg::AVG_WINDOW);
      lux_carry = 10'(total % alb_smth_pkg::AVG_WINDOW);
      target = level_for_lux(lux_avg);
      if (target > level_held) level_held = level_held + 1'b1;
      else if (target < level_held) level_held = level_held - 1'b1;
      return level_held;
   endfunction

   task automatic log_error(input string msg);
      if (error_count < 10) $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic write_csr(input logic [alb_smth_pkg::CSR_IDX_W-1:0] idx,
                            input logic [alb_smth_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         alb_smth_pkg::CSR_LUX_SHIFT: cfg_shift = data[alb_smth_pkg::SHIFT_W-1:0];
         alb_smth_pkg::CSR_MIN_LEVEL: cfg_min_level = data;
         alb_smth_pkg::CSR_MAX_LEVEL: cfg_max_level = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (lux_backlog.size() != 0 || req_valid || brightness_due.size() != 0);
   endtask

   // mostly steady runs with jitter, some noise, clamp-range and near-dark samples
   task automatic queue_random_light(input int count);
      int unsigned pick;
      int unsigned base;
      int unsigned run_len;
      int v;
      int i;
      while (count > 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            base = $urandom_range(0, LUX_TOP) >> $urandom_range(0, 12);
            run_len = $urandom_range(8, 40);
            for (i = 0; i < run_len && count > 0; i++) begin
               v = int'(base) + int'($urandom_range(0, 2000)) - 1000;
               if (v < 0) v = 0;
               if (v > LUX_TOP) v = LUX_TOP;
               lux_backlog.push_back(alb_smth_pkg::LUX_W'(v));
               count--;
            end
         end else begin
            if (pick == 7) begin
               lux_backlog.push_back(alb_smth_pkg::LUX_W'($urandom()));
            end else if (pick == 8) begin
               lux_backlog.push_back(alb_smth_pkg::LUX_W'(
                  $urandom_range(alb_smth_pkg::LUX_MAX, LUX_TOP)));
            end else begin
               lux_backlog.push_back(alb_smth_pkg::LUX_W'($urandom_range(0, 255)));
            end
            count--;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            brightness_due.push_back(advance_brightness(req_ambient_lux));
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (lux_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_ambient_lux <= lux_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (brightness_due.size() == 0) begin
               log_error($sformatf("brightness %0d with no sample outstanding",
                                   rsp_brightness));
            end else begin
               want_level = brightness_due.pop_front();
               if (rsp_brightness !== want_level)
                  log_error($sformatf("result %0d: brightness expected %0d, got %0d",
                                      results_checked, want_level, rsp_brightness));
               results_checked++;
            end
         end
         rsp_stall <= $urandom_range(0, 99) < recv_stall_pct;
      end
   end

   initial begin
      int unsigned plain_run[10] = '{0, 2097151, 1573000, 1573001, 1572999,
                                     21'h155555, 21'h0AAAAA, 1, 0, 2097151};
      int unsigned wide_run[8] = '{2097151, 2097151, 0, 500, 1573000, 12345, 0, 2000000};
      int unsigned crossed_run[6] = '{2097151, 0, 40000, 1573000, 7, 1048576};
      int unsigned idle_send[4] = '{0, 72, 0, 23};
      int unsigned idle_recv[4] = '{0, 0, 72, 23};
      int p;

      cfg_shift = alb_smth_pkg::SHIFT_W'(alb_smth_pkg::RESET_SHIFT);
      cfg_min_level = alb_smth_pkg::LEVEL_W'(alb_smth_pkg::RESET_MIN);
      cfg_max_level = alb_smth_pkg::LEVEL_W'(alb_smth_pkg::RESET_MAX);
      lux_avg = alb_smth_pkg::LUX_W'(alb_smth_pkg::START_LUX);
      lux_carry = '0;
      level_held = level_for_lux(alb_smth_pkg::LUX_W'(alb_smth_pkg::START_LUX));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings
      foreach (plain_run[i]) lux_backlog.push_back(alb_smth_pkg::LUX_W'(plain_run[i]));
      wait_drained();

      // no shift, full range, upper data bits of the shift ignored
      write_csr(alb_smth_pkg::CSR_LUX_SHIFT, 8'hF0);
      write_csr(alb_smth_pkg::CSR_MIN_LEVEL, 8'd0);
      write_csr(alb_smth_pkg::CSR_MAX_LEVEL, 8'd255);
      write_csr(CSR_UNMAPPED, 8'hFF);
      settings_used++;
      foreach (wide_run[i]) lux_backlog.push_back(alb_smth_pkg::LUX_W'(wide_run[i]));
      wait_drained();

      // largest shift with the minimum above the maximum
      write_csr(alb_smth_pkg::CSR_LUX_SHIFT, 8'h0F);
      write_csr(alb_smth_pkg::CSR_MIN_LEVEL, 8'd200);
      write_csr(alb_smth_pkg::CSR_MAX_LEVEL, 8'd30);
      settings_used++;
      foreach (crossed_run[i]) lux_backlog.push_back(alb_smth_pkg::LUX_W'(crossed_run[i]));
      wait_drained();

      for (p = 0; p < 4; p++) begin
         if (p % 2 == 0) begin
            write_csr(alb_smth_pkg::CSR_LUX_SHIFT,
                      {4'($urandom()), 4'($urandom_range(5, 12))});
            write_csr(alb_smth_pkg::CSR_MIN_LEVEL, 8'($urandom_range(0, 60)));
            write_csr(alb_smth_pkg::CSR_MAX_LEVEL, 8'($urandom_range(100, 255)));
         end else begin
            write_csr(alb_smth_pkg::CSR_LUX_SHIFT, 8'($urandom()));
            write_csr(alb_smth_pkg::CSR_MIN_LEVEL, 8'($urandom()));
            write_csr(alb_smth_pkg::CSR_MAX_LEVEL, 8'($urandom()));
         end
         write_csr(CSR_UNMAPPED, 8'($urandom()));
         settings_used++;
         send_idle_pct = idle_send[p];
         recv_stall_pct = idle_recv[p];
         queue_random_light(125);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("%0d light samples over %0d register settings, %0d csr writes",
               samples_taken, settings_used, csr_writes);
      $display("%0d brightness items checked across four idle and stall mixes, %0d errors",
               results_checked, error_count);
      if (error_count == 0) begin
         $display("ambient_light_brightness_smoother_unit verification clean");
      end else begin
         $display("ambient_light_brightness_smoother_unit verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", brightness_due.size());
      $display("ambient_light_brightness_smoother_unit verification failed");
      $finish;
   end

endmodule
